// File: rtl/core/spe_pkg.sv
// ----------------------------------------------------------------------------
// spe_pkg
// Types and constants shared by the shortest path engine.
// ----------------------------------------------------------------------------
package spe_pkg;

    localparam int NODE_BITS      = 6;
    localparam int WEIGHT_IN_BITS = 16;
    localparam int DIST_BITS      = 23;
    localparam int PATH_CAP       = 64;
    localparam int PATH_IDX_BITS  = 6;
    localparam int PATH_LEN_BITS  = 7;

    localparam int MAX_NODES_DEF   = 64;
    localparam int MAX_EDGES_DEF   = 256;
    localparam int WEIGHT_BITS_DEF = 16;

    localparam logic [DIST_BITS-1:0] DIST_INF = '1;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]                op;
        logic [NODE_BITS-1:0]      node_a;
        logic [NODE_BITS-1:0]      node_b;
        logic [WEIGHT_IN_BITS-1:0] weight;
    } t_in_item;

    typedef struct packed {
        logic [NODE_BITS-1:0] path_node;
        logic                 is_last;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_FIND,
        ST_SETTLE,
        ST_ED_RD,
        ST_ED_CHK,
        ST_ED_UPD,
        ST_WALK_RD,
        ST_WALK_CHK,
        ST_EMIT_RD,
        ST_EMIT_LD
    } t_state;

endpackage

// File: rtl/core/shortest_path_engine_unit.sv
// ----------------------------------------------------------------------------
// shortest_path_engine_unit
// Dijkstra shortest path over an undirected graph held in on-chip memories.
// ----------------------------------------------------------------------------
// Usage: items enter on i_in_valid/o_in_ready. op clear empties the edge
// store, op add appends one edge if there is room and both nodes are in
// range, op query runs a search from node_a and returns the path to node_b
// as o_out_valid/i_out_ready items, start first, is_last set on the end node.
// Clear and add are accepted back to back.
// A query with equal or out-of-range nodes gives the end node alone.
// Otherwise each round scans the node memory for the minimum, settles it
// and walks the stored edges, reading and checking each edge, with an extra
// read-check-update of the single-port node memory on an incident edge; a
// last scan finds nothing left to settle. The predecessors are then walked
// back from the end node and the path is emitted. Input is held off while a
// query runs.
// The output register parts the two sides: a new item is taken while the
// last result waits; a stalled receiver holds the emission of further nodes.
// Reset clears state, edge count and output valid; memories need no clearing.
// ----------------------------------------------------------------------------
module shortest_path_engine_unit #(
    parameter int MAX_NODES   = spe_pkg::MAX_NODES_DEF,
    parameter int MAX_EDGES   = spe_pkg::MAX_EDGES_DEF,
    parameter int WEIGHT_BITS = spe_pkg::WEIGHT_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  spe_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output spe_pkg::t_out_item  o_out_item
);
    import spe_pkg::*;

    localparam int NW  = $clog2(MAX_NODES);
    localparam int CW  = $clog2(MAX_NODES + 1);
    localparam int EW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int SW  = ((DIST_BITS > WEIGHT_BITS) ? DIST_BITS : WEIGHT_BITS) + 1;

    typedef struct packed {
        logic                 settled;
        logic                 pvalid;
        logic [NW-1:0]        pred;
        logic [DIST_BITS-1:0] cost;
    } t_node;

    typedef struct packed {
        logic [NW-1:0]          a;
        logic [NW-1:0]          b;
        logic [WEIGHT_BITS-1:0] w;
    } t_edge;

    // memories
    t_node                  node_mem [MAX_NODES];
    t_edge                  edge_mem [MAX_EDGES];
    logic [NODE_BITS-1:0]   path_mem [PATH_CAP];

    t_node                  node_q;
    t_edge                  edge_q;
    logic [NODE_BITS-1:0]   path_q;

    logic                   node_re, node_we;
    logic [NW-1:0]          node_addr;
    t_node                  node_wdata;
    logic                   edge_re, edge_we;
    logic [EW-1:0]          edge_addr;
    t_edge                  edge_wdata;
    logic                   path_re, path_we;
    logic [PATH_IDX_BITS-1:0] path_addr;
    logic [NODE_BITS-1:0]   path_wdata;

    // registers
    t_state                 r_state, n_state;
    logic [ECW-1:0]         r_edge_count, n_edge_count;
    logic [NW-1:0]          r_start, n_start;
    logic [NW-1:0]          r_end, n_end;
    logic [CW-1:0]          r_i, n_i;
    logic                   r_found, n_found;
    logic [NW-1:0]          r_best, n_best;
    t_node                  r_best_node, n_best_node;
    logic [ECW-1:0]         r_e, n_e;
    logic [NW-1:0]          r_tgt, n_tgt;
    logic [WEIGHT_BITS-1:0] r_w, n_w;
    logic [NW-1:0]          r_v, n_v;
    logic [PATH_LEN_BITS-1:0] r_n, n_n;
    logic [PATH_IDX_BITS-1:0] r_idx, n_idx;
    logic                   r_out_valid, n_out_valid;
    t_out_item              r_out_item, n_out_item;

    logic                   in_fire;
    logic                   add_ok;
    logic                   q_bad;
    logic                   take;
    logic [SW-1:0]          sum;
    logic [DIST_BITS-1:0]   cand;
    logic [NW-1:0]          scan_id;

    assign in_fire     = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign add_ok = (32'(r_edge_count) < MAX_EDGES)
                 && (32'(i_in_item.node_a) < MAX_NODES)
                 && (32'(i_in_item.node_b) < MAX_NODES);
    assign q_bad  = (32'(i_in_item.node_a) >= MAX_NODES)
                 || (32'(i_in_item.node_b) >= MAX_NODES)
                 || (i_in_item.node_a == i_in_item.node_b);

    // saturating relaxation candidate
    assign sum  = SW'(r_best_node.cost) + SW'(r_w);
    assign cand = (sum > SW'(DIST_INF)) ? DIST_INF : DIST_BITS'(sum);

    // node whose read data is present during the minimum scan
    assign scan_id = NW'(r_i - CW'(1));
    assign take = (r_i != '0) && !node_q.settled && (node_q.cost != DIST_INF)
               && (!r_found || (node_q.cost < r_best_node.cost));

    always_comb begin
        n_state      = r_state;
        n_edge_count = r_edge_count;
        n_start      = r_start;
        n_end        = r_end;
        n_i          = r_i;
        n_found      = r_found;
        n_best       = r_best;
        n_best_node  = r_best_node;
        n_e          = r_e;
        n_tgt        = r_tgt;
        n_w          = r_w;
        n_v          = r_v;
        n_n          = r_n;
        n_idx        = r_idx;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_item   = r_out_item;

        node_re    = 1'b0;
        node_we    = 1'b0;
        node_addr  = '0;
        node_wdata = node_q;
        edge_re    = 1'b0;
        edge_we    = 1'b0;
        edge_addr  = '0;
        edge_wdata = '0;
        path_re    = 1'b0;
        path_we    = 1'b0;
        path_addr  = '0;
        path_wdata = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    priority if (i_in_item.op == OP_CLEAR) begin
                        n_edge_count = '0;
                    end else if (i_in_item.op == OP_ADD) begin
                        if (add_ok) begin
                            edge_we      = 1'b1;
                            edge_addr    = EW'(r_edge_count);
                            edge_wdata.a = NW'(i_in_item.node_a);
                            edge_wdata.b = NW'(i_in_item.node_b);
                            edge_wdata.w = WEIGHT_BITS'(i_in_item.weight);
                            n_edge_count = r_edge_count + ECW'(1);
                        end
                    end else if (i_in_item.op == OP_QUERY) begin
                        // the end node always heads the reversed path
                        path_we    = 1'b1;
                        path_addr  = '0;
                        path_wdata = i_in_item.node_b;
                        n_start    = NW'(i_in_item.node_a);
                        n_end      = NW'(i_in_item.node_b);
                        n_n        = PATH_LEN_BITS'(1);
                        if (q_bad) begin
                            n_idx   = '0;
                            n_state = ST_EMIT_RD;
                        end else begin
                            n_i     = '0;
                            n_state = ST_INIT;
                        end
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_INIT: begin
                node_we            = 1'b1;
                node_addr          = NW'(r_i);
                node_wdata.settled = 1'b0;
                node_wdata.pvalid  = 1'b0;
                node_wdata.pred    = '0;
                node_wdata.cost    = (NW'(r_i) == r_start) ? '0 : DIST_INF;
                if (r_i == CW'(MAX_NODES - 1)) begin
                    n_i     = '0;
                    n_found = 1'b0;
                    n_state = ST_FIND;
                end else begin
                    n_i = r_i + CW'(1);
                end
            end
            ST_FIND: begin
                if (32'(r_i) < MAX_NODES) begin
                    node_re   = 1'b1;
                    node_addr = NW'(r_i);
                end
                if (take) begin
                    n_found     = 1'b1;
                    n_best      = scan_id;
                    n_best_node = node_q;
                end
                if (r_i == CW'(MAX_NODES)) begin
                    if (r_found || take) begin
                        n_state = ST_SETTLE;
                    end else begin
                        n_v     = r_end;
                        n_state = ST_WALK_RD;
                    end
                end else begin
                    n_i = r_i + CW'(1);
                end
            end
            ST_SETTLE: begin
                node_we            = 1'b1;
                node_addr          = r_best;
                node_wdata         = r_best_node;
                node_wdata.settled = 1'b1;
                n_e                = '0;
                if (r_edge_count == '0) begin
                    n_i     = '0;
                    n_found = 1'b0;
                    n_state = ST_FIND;
                end else begin
                    n_state = ST_ED_RD;
                end
            end
            ST_ED_RD: begin
                edge_re   = 1'b1;
                edge_addr = EW'(r_e);
                n_state   = ST_ED_CHK;
            end
            ST_ED_CHK: begin
                if (edge_q.a == r_best || edge_q.b == r_best) begin
                    n_tgt     = (edge_q.a == r_best) ? edge_q.b : edge_q.a;
                    n_w       = edge_q.w;
                    node_re   = 1'b1;
                    node_addr = (edge_q.a == r_best) ? edge_q.b : edge_q.a;
                    n_state   = ST_ED_UPD;
                end else begin
                    n_e = r_e + ECW'(1);
                    if (r_e + ECW'(1) == r_edge_count) begin
                        n_i     = '0;
                        n_found = 1'b0;
                        n_state = ST_FIND;
                    end else begin
                        n_state = ST_ED_RD;
                    end
                end
            end
            ST_ED_UPD: begin
                if (cand < node_q.cost) begin
                    node_we           = 1'b1;
                    node_addr         = r_tgt;
                    node_wdata.pvalid = 1'b1;
                    node_wdata.pred   = r_best;
                    node_wdata.cost   = cand;
                end
                n_e = r_e + ECW'(1);
                if (r_e + ECW'(1) == r_edge_count) begin
                    n_i     = '0;
                    n_found = 1'b0;
                    n_state = ST_FIND;
                end else begin
                    n_state = ST_ED_RD;
                end
            end
            ST_WALK_RD: begin
                node_re   = 1'b1;
                node_addr = r_v;
                n_state   = ST_WALK_CHK;
            end
            ST_WALK_CHK: begin
                if (node_q.pvalid && (r_n < PATH_LEN_BITS'(PATH_CAP))) begin
                    path_we    = 1'b1;
                    path_addr  = PATH_IDX_BITS'(r_n);
                    path_wdata = NODE_BITS'(node_q.pred);
                    n_v        = node_q.pred;
                    n_n        = r_n + PATH_LEN_BITS'(1);
                    n_state    = ST_WALK_RD;
                end else begin
                    n_idx   = PATH_IDX_BITS'(r_n - PATH_LEN_BITS'(1));
                    n_state = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD: begin
                path_re   = 1'b1;
                path_addr = r_idx;
                n_state   = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                // path_q holds until the next read, so waiting here is safe
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid          = 1'b1;
                    n_out_item.path_node = path_q;
                    n_out_item.is_last   = (r_idx == '0);
                    if (r_idx == '0) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx   = r_idx - PATH_IDX_BITS'(1);
                        n_state = ST_EMIT_RD;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_edge_count <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_edge_count <= n_edge_count;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_start     <= n_start;
        r_end       <= n_end;
        r_i         <= n_i;
        r_found     <= n_found;
        r_best      <= n_best;
        r_best_node <= n_best_node;
        r_e         <= n_e;
        r_tgt       <= n_tgt;
        r_w         <= n_w;
        r_v         <= n_v;
        r_n         <= n_n;
        r_idx       <= n_idx;
        r_out_item  <= n_out_item;
    end

    always_ff @(posedge i_clk) begin
        if (node_we) begin
            node_mem[node_addr] <= node_wdata;
        end
        if (node_re) begin
            node_q <= node_mem[node_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (edge_we) begin
            edge_mem[edge_addr] <= edge_wdata;
        end
        if (edge_re) begin
            edge_q <= edge_mem[edge_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (path_we) begin
            path_mem[path_addr] <= path_wdata;
        end
        if (path_re) begin
            path_q <= path_mem[path_addr];
        end
    end

    // assertions
    a_edge_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_edge_count) <= MAX_EDGES)
        else $error("edge count beyond capacity");

    a_path_len_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK_RD || r_state == ST_WALK_CHK)
            |-> (r_n <= PATH_LEN_BITS'(PATH_CAP)))
        else $error("path length beyond buffer");

    a_more_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.is_last)
            |-> (r_state == ST_EMIT_RD || r_state == ST_EMIT_LD))
        else $error("non-final path node without emission in progress");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Loads random and directed graphs, runs path queries and checks every
// returned path node against a behavioral Dijkstra predictor.
// ----------------------------------------------------------------------------
module tb;
    import spe_pkg::*;

    localparam int NNODES   = MAX_NODES_DEF;
    localparam int NEDGES   = MAX_EDGES_DEF;
    localparam int WD_LIMIT = 400000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;

    shortest_path_engine_unit uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(in_valid),
        .o_in_ready(in_ready),
        .i_in_item(in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item(out_item)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [5:0]  g_a [NEDGES];
    logic [5:0]  g_b [NEDGES];
    logic [15:0] g_w [NEDGES];
    int          g_count = 0;

    t_in_item  pending_q[$];
    t_out_item path_q[$];
    int        errors = 0;
    int        accepted = 0;
    int        sent = 0;
    int        hold_gap = 0;
    int        out_gap = 0;
    int        idle_cycles = 0;
    bit        drain_req = 1'b0;

    task automatic report(input string msg);
        $display("mismatch @%0t: %s", $time, msg);
        errors++;
    endtask

    task automatic enqueue(input t_in_item it);
        pending_q.insert(pending_q.size(), it);
    endtask

    task automatic expect_node(input logic [5:0] node, input bit last);
        t_out_item o;
        o.path_node = node;
        o.is_last = last;
        path_q.insert(path_q.size(), o);
    endtask

    task automatic predict_path(input t_in_item it);
        logic [22:0] cost [NNODES];
        bit          pv   [NNODES];
        logic [5:0]  pn   [NNODES];
        bit          done [NNODES];
        logic [5:0]  walk [$];
        logic [23:0] cand;
        logic [5:0]  v;
        int best;
        bit found;
        case (it.op)
            OP_CLEAR: g_count = 0;
            OP_ADD: begin
                if (g_count < NEDGES) begin
                    g_a[g_count] = it.node_a;
                    g_b[g_count] = it.node_b;
                    g_w[g_count] = it.weight;
                    g_count++;
                end
            end
            OP_QUERY: begin
                if (it.node_a == it.node_b) begin
                    expect_node(it.node_b, 1'b1);
                end else begin
                    for (int i = 0; i < NNODES; i++) begin
                        cost[i] = DIST_INF;
                        pv[i] = 0;
                        pn[i] = 0;
                        done[i] = 0;
                    end
                    cost[it.node_a] = 0;
                    for (int r = 0; r < NNODES; r++) begin
                        found = 0;
                        best = 0;
                        for (int i = 0; i < NNODES; i++)
                            if (!done[i] && cost[i] < DIST_INF &&
                                (!found || cost[i] < cost[best])) begin
                                found = 1;
                                best = i;
                            end
                        if (!found) break;
                        done[best] = 1;
                        for (int e = 0; e < g_count; e++) begin
                            for (int s = 0; s < 2; s++) begin
                                logic [5:0] me, other;
                                me = s ? g_b[e] : g_a[e];
                                other = s ? g_a[e] : g_b[e];
                                if (me == best) begin
                                    cand = {1'b0, cost[best]} + g_w[e];
                                    if (cand > DIST_INF) cand = DIST_INF;
                                    if (cand[22:0] < cost[other]) begin
                                        cost[other] = cand[22:0];
                                        pv[other] = 1;
                                        pn[other] = best[5:0];
                                    end
                                end
                            end
                        end
                    end
                    v = it.node_b;
                    walk.push_front(v);
                    while (walk.size() < PATH_CAP && pv[v]) begin
                        v = pn[v];
                        walk.push_front(v);
                    end
                    foreach (walk[k])
                        expect_node(walk[k], k == walk.size() - 1);
                end
            end
            default: ;
        endcase
    endtask

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && accepted != sent) begin
                // hold
            end else if (hold_gap > 0) begin
                in_valid <= 1'b0;
                hold_gap <= hold_gap - 1;
            end else if (pending_q.size() > 0 && !(drain_req && path_q.size() > 0)) begin
                in_valid <= 1'b1;
                in_item  <= pending_q.pop_front();
                sent     <= sent + 1;
                hold_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9) : 0;
            end else begin
                in_valid <= 1'b0;
            end
            if (out_gap > 0) begin
                out_ready <= 1'b0;
                out_gap <= out_gap - 1;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (in_valid && in_ready) begin
                predict_path(in_item);
                accepted <= accepted + 1;
            end
            if (out_valid && out_ready) begin
                if ($urandom_range(0, 2) == 0) out_gap <= $urandom_range(0, 9);
                if (path_q.size() == 0) begin
                    report($sformatf("unexpected node %0d", out_item.path_node));
                end else begin
                    t_out_item exp_item;
                    exp_item = path_q.pop_front();
                    if (out_item.path_node !== exp_item.path_node)
                        report($sformatf("path_node %0d, expected %0d",
                            out_item.path_node, exp_item.path_node));
                    if (out_item.is_last !== exp_item.is_last)
                        report($sformatf("is_last %0b, expected %0b",
                            out_item.is_last, exp_item.is_last));
                end
            end
            if (idle_cycles >= WD_LIMIT) begin
                $display("** shortest_path_engine_unit: FAILED **");
                $finish;
            end
        end
    end

    function automatic t_in_item mk(input logic [1:0] op, input int a, input int b,
                                    input int w);
        t_in_item it;
        it.op = op;
        it.node_a = a[5:0];
        it.node_b = b[5:0];
        it.weight = w[15:0];
        return it;
    endfunction

    // a clear, a random graph on the given node count, then queries on it
    task automatic queue_graph(input int nodes, input int edges, input int queries,
                               input bit heavy);
        enqueue(mk(OP_CLEAR, $urandom, $urandom, $urandom));
        for (int i = 0; i < edges; i++)
            enqueue(mk(OP_ADD, $urandom_range(0, nodes - 1),
                $urandom_range(0, nodes - 1),
                heavy ? $urandom_range(40000, 65535) : $urandom_range(0, 30)));
        for (int i = 0; i < queries; i++)
            enqueue(mk(($urandom_range(0, 9) == 0) ? OP_UNUSED : OP_QUERY,
                $urandom_range(0, nodes - 1), $urandom_range(0, nodes - 1),
                $urandom));
    endtask

    initial begin
        // directed: extremes, self loop, unreachable, equal ends, unused op
        enqueue(mk(OP_QUERY, 0, 63, 0));
        enqueue(mk(OP_ADD, 0, 63, 16'hFFFF));
        enqueue(mk(OP_ADD, 63, 63, 0));
        enqueue(mk(OP_ADD, 63, 1, 16'hFFFF));
        enqueue(mk(OP_ADD, 0, 2, 5));
        enqueue(mk(OP_ADD, 2, 1, 5));
        enqueue(mk(OP_ADD, 1, 3, 0));
        enqueue(mk(OP_QUERY, 0, 1, 0));
        enqueue(mk(OP_QUERY, 63, 3, 16'hFFFF));
        enqueue(mk(OP_QUERY, 5, 5, 0));
        enqueue(mk(OP_QUERY, 0, 40, 0));
        enqueue(mk(OP_UNUSED, 63, 63, 16'hFFFF));
        enqueue(mk(OP_QUERY, 3, 0, 0));
        // long chain of maximum weights across every node
        enqueue(mk(OP_CLEAR, 0, 0, 0));
        for (int i = 0; i < 63; i++)
            enqueue(mk(OP_ADD, i, i + 1, 16'hFFFF));
        enqueue(mk(OP_QUERY, 0, 63, 0));
        enqueue(mk(OP_QUERY, 0, 20, 0));
        enqueue(mk(OP_QUERY, 40, 0, 0));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // once the directed part is sent, hold items back while path nodes are due
        wait (pending_q.size() == 0);
        drain_req = 1'b1;
        for (int g = 0; g < 6; g++)
            queue_graph($urandom_range(2, 16), $urandom_range(1, 12),
                        $urandom_range(2, 4), g % 3 == 2);
        queue_graph(64, 24, 3, 1'b0);
        wait (pending_q.size() == 0);
        drain_req = 1'b0;
        for (int g = 0; g < 5; g++)
            queue_graph($urandom_range(2, 12), $urandom_range(1, 12),
                        $urandom_range(1, 4), 1'b0);
        wait (pending_q.size() == 0 && !in_valid);
        wait (path_q.size() == 0);
        repeat (200) @(posedge i_clk);
        if (errors == 0 && path_q.size() == 0) begin
            $display("** shortest_path_engine_unit: PASSED **");
        end else begin
            $display("** shortest_path_engine_unit: FAILED **");
        end
        $finish;
    end
endmodule
